// ===== rtl/rpg_pkg.sv =====
// Shared types, constants and helper functions of the random permutation generator.
`timescale 1ns / 1ps

package rpg_pkg;

  // Permutation store sizing; the store never holds more than 64 entries.
  localparam int MAX_LENGTH  = 64;
  localparam int RESULT_CAP  = 64;
  localparam int STORE_DEPTH = (MAX_LENGTH < RESULT_CAP) ? MAX_LENGTH : RESULT_CAP;
  localparam int STORE_AW    = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;

  // Fixed field widths.
  localparam int VALUE_W = 6;
  localparam int LEN_W   = 7;
  localparam int SEED_W  = 48;

  // A sample has at most as many bits as a store index.
  localparam int DRAW_W   = STORE_AW;
  localparam int SAMPLE_W = $clog2(DRAW_W + 1);

  // Generator constants: state = state * 0x5DEECE66D + 0xB mod 2^48.
  localparam logic [34:0]       LCG_MUL    = 35'h5DEECE66D;
  localparam logic [31:0]       LCG_MUL_LO = LCG_MUL[31:0];
  localparam logic [2:0]        LCG_MUL_HI = LCG_MUL[34:32];
  localparam logic [SEED_W-1:0] LCG_INC    = 48'hB;
  localparam int                LCG_BIT    = 17;

  // Shuffle modes.
  localparam logic MODE_FISHER_YATES = 1'b0;
  localparam logic MODE_NAIVE        = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_NEXT,
    S_DSTART,
    S_DRAW,
    S_RDA,
    S_RDB,
    S_WRA,
    S_WRB,
    S_EMRD,
    S_EMLD,
    S_EMWAIT
  } rpg_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctrl_t;

  // Smallest n >= 1 with 2^n >= m.
  function automatic logic [SAMPLE_W-1:0] sample_width(input logic [LEN_W-1:0] m);
    int n;
    n = 1;
    for (int i = 1; i < DRAW_W; i++) begin
      if ((1 << i) < int'(m)) begin
        n = i + 1;
      end
    end
    return SAMPLE_W'(n);
  endfunction

endpackage

// ===== rtl/rpg_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rpg_lcg.sv =====
// 48-bit linear congruential generator; each step registers partial products before updating the state.
`timescale 1ns / 1ps

module rpg_lcg (
  input  logic                      clk,
  input  logic                      rst,
  input  rpg_pkg::lcg_ctrl_t        ctrl,
  input  logic [rpg_pkg::SEED_W-1:0] seed,
  output logic [rpg_pkg::SEED_W-1:0] lcg_state,
  output logic                      done
);
  import rpg_pkg::*;

  logic              busy;
  logic [55:0]       prod_lo_full;
  logic [47:0]       prod_mid_full;
  logic [18:0]       prod_hi_full;
  logic [47:0]       prod_lo;
  logic [23:0]       prod_mid;
  logic [15:0]       prod_hi;
  logic [SEED_W-1:0] lcg_state_next;

  // The 48 x 35 product is split into three partial products, each kept only
  // as far as it reaches into the low 48 bits.
  assign prod_lo_full  = 56'(lcg_state[23:0]) * 56'(LCG_MUL_LO);
  assign prod_mid_full = 48'(lcg_state[47:24]) * 48'(LCG_MUL_LO[23:0]);
  assign prod_hi_full  = 19'(lcg_state[15:0]) * 19'(LCG_MUL_HI);

  assign lcg_state_next = prod_lo + {prod_mid, 24'b0} + {prod_hi, 32'b0} + LCG_INC;

  always_ff @(posedge clk) begin
    if (ctrl.step && !busy) begin
      prod_lo  <= prod_lo_full[47:0];
      prod_mid <= prod_mid_full[23:0];
      prod_hi  <= prod_hi_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
      busy      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.load) begin
        lcg_state <= seed;
        busy      <= 1'b0;
      end else if (busy) begin
        lcg_state <= lcg_state_next;
        busy      <= 1'b0;
        done      <= 1'b1;
      end else if (ctrl.step) begin
        busy <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/random_permutation_generator_core.sv =====
// Top level of the random permutation generator: sequencer, store and generator.
`timescale 1ns / 1ps

// Channel  | Beat fields                     | Handshake
// ---------+---------------------------------+---------------------------
// in       | perm_length[6:0], seed_state    | in_valid / in_stall
// out      | perm_value[5:0], last_value     | out_valid / out_stall
// cfg      | cfg_wdata (shuffle_mode)        | cfg_we, no wait
//
// An accepted input beat of length L first loads the identity into the store
// (S_INIT). Each swap then passes S_NEXT and S_DSTART, one generator step per
// sample bit (including rejected samples) in S_DRAW, and the store states
// S_RDA, S_RDB, S_WRA and S_WRB; a last visit to S_NEXT closes the shuffle.
// Each output beat passes S_EMRD, S_EMLD and S_EMWAIT. The generator's 48-bit
// multiply is registered in partial products; the store has one read port.
// Reset (rst, synchronous) clears the sequencer, the generator and the mode;
// the store is not cleared, since every request writes it before reading.
// in_stall is high whenever a request is in flight; out_stall holds the
// current output beat until it is taken.

module random_permutation_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  perm_length,
  input  logic [47:0] seed_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  perm_value,
  output logic        last_value,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import rpg_pkg::*;

  rpg_state_t state, state_next;

  // Configuration.
  logic shuffle_mode;

  // Request context.
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    swap_position;
  logic [LEN_W-1:0]    draw_limit;
  logic [SAMPLE_W-1:0] sample_bits;
  logic [SAMPLE_W-1:0] bit_count;
  logic [DRAW_W-1:0]   draw_value;
  logic [STORE_AW-1:0] target;
  logic [VALUE_W-1:0]  hold_a;

  // Store port.
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [STORE_AW-1:0] ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  // Generator.
  lcg_ctrl_t         lcg_ctrl;
  logic [SEED_W-1:0] lcg_state;
  logic              lcg_done;

  // Helper terms.
  logic                in_fire;
  logic [LEN_W-1:0]    len_sat;
  logic [LEN_W-1:0]    pos_inc;
  logic                shuffle_done;
  logic [LEN_W-1:0]    limit_now;
  logic [DRAW_W-1:0]   draw_value_next;
  logic                draw_full;
  logic                draw_hit;
  logic [STORE_AW-1:0] pos_idx;

  assign in_fire   = in_valid && !in_stall;
  assign len_sat   = (perm_length > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : perm_length;
  assign pos_inc   = swap_position + 1'b1;
  assign pos_idx   = swap_position[STORE_AW-1:0];

  // Fisher-Yates stops one short of the end; the naive shuffle visits every entry.
  assign shuffle_done = (shuffle_mode == MODE_NAIVE) ? (swap_position >= len)
                                                     : (pos_inc >= len);
  assign limit_now    = (shuffle_mode == MODE_NAIVE) ? len : (len - swap_position);

  // Sample bits arrive most significant first, one per generator step.
  assign draw_value_next = {draw_value[DRAW_W-2:0], lcg_state[LCG_BIT]};
  assign draw_full       = (SAMPLE_W'(bit_count + 1'b1) == sample_bits);
  assign draw_hit        = (LEN_W'(draw_value_next) < draw_limit);

  rpg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpg_lcg u_lcg (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lcg_ctrl),
    .seed      (seed_state),
    .lcg_state (lcg_state),
    .done      (lcg_done)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && perm_length != '0) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        if (pos_inc == len) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        state_next = shuffle_done ? S_EMRD : S_DSTART;
      end
      S_DSTART: begin
        state_next = S_DRAW;
      end
      S_DRAW: begin
        if (lcg_done && draw_full && draw_hit) begin
          state_next = S_RDA;
        end
      end
      S_RDA:    state_next = S_RDB;
      S_RDB:    state_next = S_WRA;
      S_WRA:    state_next = S_WRB;
      S_WRB:    state_next = S_NEXT;
      S_EMRD:   state_next = S_EMLD;
      S_EMLD:   state_next = S_EMWAIT;
      S_EMWAIT: begin
        if (!out_stall) begin
          state_next = last_value ? S_IDLE : S_EMRD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Output logic: store port, generator control and input stall.
  always_comb begin
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = pos_idx;
    ram_wdata     = ram_rdata;
    ram_raddr     = pos_idx;
    lcg_ctrl.load = 1'b0;
    lcg_ctrl.step = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall      = 1'b0;
        lcg_ctrl.load = in_valid && perm_length != '0;
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = VALUE_W'(swap_position);
      end
      S_DSTART: begin
        lcg_ctrl.step = 1'b1;
      end
      S_DRAW: begin
        // Keep the generator running unless this bit completes an accepted sample.
        lcg_ctrl.step = lcg_done && !(draw_full && draw_hit);
      end
      S_RDB: begin
        ram_raddr = target;
      end
      S_WRA: begin
        ram_we = 1'b1;
      end
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = target;
        ram_wdata = hold_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      shuffle_mode <= MODE_FISHER_YATES;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        shuffle_mode <= cfg_wdata;
      end
      if (state == S_EMLD) begin
        out_valid <= 1'b1;
      end else if (state == S_EMWAIT && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        len           <= len_sat;
        swap_position <= '0;
      end
      S_INIT: begin
        swap_position <= (pos_inc == len) ? '0 : pos_inc;
      end
      S_NEXT: begin
        draw_limit  <= limit_now;
        sample_bits <= sample_width(limit_now);
        if (shuffle_done) begin
          swap_position <= '0;
        end
      end
      S_DSTART: begin
        bit_count  <= '0;
        draw_value <= '0;
      end
      S_DRAW: begin
        if (lcg_done) begin
          if (!draw_full) begin
            bit_count  <= SAMPLE_W'(bit_count + 1'b1);
            draw_value <= draw_value_next;
          end else if (draw_hit) begin
            target <= (shuffle_mode == MODE_NAIVE) ? STORE_AW'(draw_value_next)
                      : STORE_AW'(swap_position + LEN_W'(draw_value_next));
          end else begin
            // Rejected sample: start over with a fresh set of bits.
            bit_count  <= '0;
            draw_value <= '0;
          end
        end
      end
      S_RDB: begin
        hold_a <= ram_rdata;
      end
      S_WRB: begin
        swap_position <= pos_inc;
      end
      S_EMLD: begin
        perm_value <= ram_rdata;
        last_value <= (pos_inc == len);
      end
      S_EMWAIT: begin
        if (!out_stall && !last_value) begin
          swap_position <= pos_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // The generator only finishes a step while a sample is being gathered.
  a_done_in_draw : assert property (@(posedge clk) disable iff (rst)
    lcg_done |-> (state == S_DRAW))
    else $error("generator step finished outside a draw");

  // An accepted sample always lands inside the active part of the store.
  a_target_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_RDA) |-> (LEN_W'(target) < len))
    else $error("swap target beyond the permutation length");

  // The last flag goes with the final index of the request.
  a_last_index : assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_value) |-> (pos_inc == len))
    else $error("last flag on a non-final element");

  // A nonzero request starts by loading the identity.
  a_start_init : assert property (@(posedge clk) disable iff (rst)
    (in_fire && perm_length != '0) |=> (state == S_INIT))
    else $error("accepted request did not start initialization");

  // An output beat is only offered while waiting for it to be taken.
  a_valid_state : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EMWAIT))
    else $error("output valid outside the emit wait");

endmodule

// ===== dv/random_permutation_generator_core_tb.sv =====
// Self-checking testbench for the random permutation generator core.
`timescale 1ns / 1ps

module random_permutation_generator_core_tb;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest request (64 elements, unlucky rejection sampling) plus the long
  // receiver hold-off stays far below this.
  localparam int unsigned QUIET_LIMIT = 40000;
  // Cycles allowed after the last expected beat before a register write or
  // the end of the run, so that ignored requests have surely drained.
  localparam int unsigned SETTLE_CYCLES = 50;
  // The receiver stops taking beats for a long stretch once, after this many
  // beats, so that the core backs up and stalls its input.
  localparam int unsigned HOLD_AT_BEAT = 2000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned RANDOM_PHASE_ITEMS = 82;

  typedef struct {
    logic [6:0]  length;
    logic [47:0] seed;
  } shuffle_req_t;

  typedef struct {
    logic [5:0] elem;
    logic       is_last;
  } perm_beat_t;

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  perm_length = '0;
  logic [47:0] seed_state = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  perm_value;
  logic        last_value;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Requests waiting to be offered, and the permutation values the core
  // still owes, oldest first.
  shuffle_req_t request_queue[$];
  perm_beat_t   shuffled_values[$];

  // Predictor state: generator, store copy and the shuffle mode last written.
  logic [47:0] gen_state = '0;
  logic [5:0]  store_copy[64];
  logic        mode_shadow = rpg_pkg::MODE_FISHER_YATES;

  // Handshake bookkeeping of the driver, the monitor and the watchdog.
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  int unsigned beats_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  shuffle_req_t next_req;
  perm_beat_t   want;

  random_permutation_generator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .perm_length (perm_length),
    .seed_state  (seed_state),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .perm_value  (perm_value),
    .last_value  (last_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One generator step; the random bit is bit 17 of the new 48-bit state.
  // The expression is evaluated at 48 bits, so the wrap is modulo 2^48.
  function automatic logic lcg_bit();
    gen_state = gen_state * rpg_pkg::LCG_MUL + rpg_pkg::LCG_INC;
    return gen_state[rpg_pkg::LCG_BIT];
  endfunction

  // Uniform integer below m by rejection: gather the fewest bits (at least
  // one) that cover m, most significant first, and redraw while too large.
  function automatic int unsigned draw_below(input int unsigned m);
    int unsigned nbits;
    int unsigned span;
    int unsigned v;
    nbits = 1;
    span = 2;
    while (span < m) begin
      nbits++;
      span = span << 1;
    end
    do begin
      v = 0;
      for (int unsigned k = 0; k < nbits; k++) begin
        v = (v << 1) | lcg_bit();
      end
    end while (v >= m);
    return v;
  endfunction

  // Predicts the whole permutation that one accepted request produces and
  // queues it. A zero length is dropped by the core without any effect, and
  // lengths above 64 are clipped to 64.
  function automatic void shuffle_request(input logic [6:0] len_raw,
                                          input logic [47:0] seed);
    int unsigned len;
    int unsigned k;
    logic [5:0]  tmp;
    len = len_raw;
    if (len == 0) begin
      return;
    end
    if (len > 64) begin
      len = 64;
    end
    gen_state = seed;
    for (int unsigned j = 0; j < len; j++) begin
      store_copy[j] = 6'(j);
    end
    if (mode_shadow == rpg_pkg::MODE_FISHER_YATES) begin
      // Each position swaps with a random position at or after itself.
      for (int unsigned j = 0; j + 1 < len; j++) begin
        k = j + draw_below(len - j);
        tmp = store_copy[j];
        store_copy[j] = store_copy[k];
        store_copy[k] = tmp;
      end
    end else begin
      // The naive shuffle swaps every position with any position at all.
      for (int unsigned j = 0; j < len; j++) begin
        k = draw_below(len);
        tmp = store_copy[j];
        store_copy[j] = store_copy[k];
        store_copy[k] = tmp;
      end
    end
    for (int unsigned j = 0; j < len; j++) begin
      shuffled_values.push_back('{elem: store_copy[j], is_last: (j + 1 == len)});
    end
  endfunction

  // Wait before the next beat on one side. Idling is switched on and off in
  // runs, so that there are also long stretches with back-to-back beats.
  function automatic int unsigned draw_wait(inout bit idle_on);
    if ($urandom_range(0, 19) == 0) begin
      idle_on = !idle_on;
    end
    return idle_on ? $urandom_range(0, 16) : 0;
  endfunction

  // Driver: offers queued requests and predicts each one as it is accepted.
  // in_valid gets at most one assignment per edge, and a stalled beat is held.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shuffle_request(perm_length, seed_state);
        in_wait = draw_wait(in_idle_on);
      end
      if (!in_valid || !in_stall) begin
        if (in_wait != 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          next_req = request_queue.pop_front();
          perm_length <= next_req.length;
          seed_state <= next_req.seed;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted beat against the oldest predicted value
  // and drives the receiver's stall, including the single long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shuffled_values.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual value %0d last %0b",
                   $time, perm_value, last_value);
        end else begin
          want = shuffled_values.pop_front();
          if (perm_value !== want.elem) begin
            mismatches++;
            $display("%0t: perm_value mismatch, expected %0d, actual %0d",
                     $time, want.elem, perm_value);
          end
          if (last_value !== want.is_last) begin
            mismatches++;
            $display("%0t: last_value mismatch, expected %0b, actual %0b",
                     $time, want.is_last, last_value);
          end
        end
        beats_taken++;
        out_wait = draw_wait(out_idle_on);
        if (beats_taken == HOLD_AT_BEAT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_wait != 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: the run is hung if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_request(input logic [6:0] len, input logic [47:0] seed);
    request_queue.push_back('{length: len, seed: seed});
  endtask

  // Writes the mode register; only called while the core is idle.
  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    mode_shadow = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every request has been taken and every value has come back.
  // Sampling on the falling edge keeps this clear of the rising-edge updates.
  // The extra cycles cover a zero-length request still being swallowed.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || in_valid || shuffled_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Corner requests: shortest and longest lengths, a zero length that must be
  // ignored, lengths above 64 that clip, lengths just above a power of two
  // where rejection is frequent, and seeds at the extremes.
  task automatic queue_directed();
    add_request(7'd1, 48'h0);
    add_request(7'd2, 48'hFFFF_FFFF_FFFF);
    add_request(7'd3, 48'h0000_0000_0001);
    add_request(7'd127, 48'hAAAA_AAAA_AAAA);
    add_request(7'd0, 48'h5555_5555_5555);
    add_request(7'd64, 48'h0);
    add_request(7'd65, 48'hFFFF_FFFF_FFFF);
    add_request(7'd33, 48'h8000_0000_0000);
    add_request(7'd63, 48'h5555_5555_5555);
    add_request(7'd17, 48'h1234_5678_9ABC);
    add_request(7'd5, 48'h0000_0002_0000);
    add_request(7'd32, {$urandom(), $urandom()});
  endtask

  // Random requests. Most lengths are short to keep the run fast; a few are
  // the full 64 or above it. Zero lengths are mixed in as noise and are not
  // counted, since the core drops them.
  task automatic queue_random(input int unsigned count);
    int unsigned added;
    int unsigned pick;
    logic [6:0]  len;
    logic [47:0] seed;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        len = 7'd0;
      end else if (pick < 60) begin
        len = 7'($urandom_range(1, 16));
      end else if (pick < 85) begin
        len = 7'($urandom_range(17, 63));
      end else if (pick < 95) begin
        len = 7'd64;
      end else begin
        len = 7'($urandom_range(65, 127));
      end
      case ($urandom_range(0, 19))
        0: begin
          seed = '0;
        end
        1: begin
          seed = '1;
        end
        default: begin
          seed = {$urandom(), $urandom()};
        end
      endcase
      add_request(len, seed);
      if (len != 0) begin
        added++;
      end
    end
  endtask

  // Test sequence: reset, the corner requests in both modes, then random
  // phases that alternate the mode, with each register write made only once
  // the core has drained.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_mode(rpg_pkg::MODE_FISHER_YATES);
    queue_directed();
    wait_drained();
    write_mode(rpg_pkg::MODE_NAIVE);
    queue_directed();
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      write_mode((p % 2 == 0) ? rpg_pkg::MODE_FISHER_YATES : rpg_pkg::MODE_NAIVE);
      queue_random(RANDOM_PHASE_ITEMS);
      wait_drained();
    end
    if (mismatches == 0 && shuffled_values.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
